// File: hdl/lwe_pkg.sv
// Shared constants, codes and pipeline types for the LWE decryption distance unit.
package lwe_pkg;

    localparam int KEY_LENGTH = 512;
    localparam int KEY_AW     = $clog2(KEY_LENGTH);
    localparam int WORD_W     = 32;
    localparam int INDEX_W    = 9;
    localparam int DIST_W     = 16;
    localparam int FRAC_W     = 16;
    localparam int IN_DATA_W  = 112;
    localparam int OUT_DATA_W = 16;

    localparam logic ACT_KEY    = 1'b0;
    localparam logic ACT_VECTOR = 1'b1;

    typedef struct packed {
        logic              valid;
        logic              last;
        logic              in_range;
        logic [WORD_W-1:0] vector_word;
        logic [WORD_W-1:0] cipher_scalar;
    } lwe_elem_t;

    typedef struct packed {
        logic              valid;
        logic [WORD_W-1:0] total;
        logic [WORD_W-1:0] cipher_scalar;
    } lwe_sum_t;

endpackage

// File: hdl/lwe_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lwe_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 512,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: hdl/lwe_mac.sv
// Multiply stage and running dot-product accumulator.
module lwe_mac
    import lwe_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  lwe_elem_t         elem,
    input  logic [WORD_W-1:0] key_word,
    output lwe_sum_t          sum
);

    logic              prod_valid_reg;
    logic              prod_last_reg;
    logic [WORD_W-1:0] prod_reg;
    logic [WORD_W-1:0] prod_scalar_reg;
    logic [WORD_W-1:0] prod_next;

    logic [WORD_W-1:0] dot_sum_reg;
    logic [WORD_W-1:0] dot_sum_next;
    logic [WORD_W-1:0] total;

    logic              sum_valid_reg;
    logic [WORD_W-1:0] sum_total_reg;
    logic [WORD_W-1:0] sum_scalar_reg;

    always_comb
    begin
        prod_next = elem.in_range ? WORD_W'(elem.vector_word * key_word) : '0;
        total     = dot_sum_reg + prod_reg;
        if (prod_valid_reg)
        begin
            dot_sum_next = prod_last_reg ? '0 : total;
        end
        else
        begin
            dot_sum_next = dot_sum_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            prod_last_reg  <= 1'b0;
            dot_sum_reg    <= '0;
            sum_valid_reg  <= 1'b0;
        end
        else if (advance)
        begin
            prod_valid_reg <= elem.valid;
            prod_last_reg  <= elem.last;
            dot_sum_reg    <= dot_sum_next;
            sum_valid_reg  <= prod_valid_reg && prod_last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            prod_reg        <= prod_next;
            prod_scalar_reg <= elem.cipher_scalar;
            sum_total_reg   <= total;
            sum_scalar_reg  <= prod_scalar_reg;
        end
    end

    assign sum.valid         = sum_valid_reg;
    assign sum.total         = sum_total_reg;
    assign sum.cipher_scalar = sum_scalar_reg;

endmodule

// File: hdl/lwe_scale.sv
// Difference, rounding to a 16-bit distance and the result register.
module lwe_scale
    import lwe_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  advance,
    input  lwe_sum_t              sum,
    output logic                  stall,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [DIST_W-1:0]     distance
);

    logic              diff_valid_reg;
    logic [WORD_W-1:0] diff_reg;

    logic              out_valid_reg;
    logic              out_valid_next;
    logic [DIST_W-1:0] distance_reg;
    logic [DIST_W-1:0] distance_next;
    logic [WORD_W-FRAC_W:0] rounded;

    always_comb
    begin
        rounded = (WORD_W-FRAC_W+1)'(diff_reg[WORD_W-2:FRAC_W-1]) + 1'b1;
        if (diff_reg[WORD_W-1])
        begin
            distance_next = '0;
        end
        else
        begin
            distance_next = DIST_W'(rounded >> 1);
        end
    end

    assign stall = diff_valid_reg && out_valid_reg && !out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance && diff_valid_reg)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            diff_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                diff_valid_reg <= sum.valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            diff_reg <= sum.cipher_scalar - sum.total;
            if (diff_valid_reg)
            begin
                distance_reg <= distance_next;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign distance  = distance_reg;

endmodule

// File: hdl/lwe_decrypt_distance.sv
// Top level of the LWE decryption distance unit: input channel, key RAM and pipeline.
//
// Input channel (s_axis): one transfer per item. tuser is the action: a key write
// stores the key word at its index, a vector element adds vector_word times the
// stored key word to the running dot product. tlast on a vector element ends the
// ciphertext and produces one result; tlast on a key write is ignored.
// Output channel (m_axis): one transfer per ciphertext, tdata is the distance,
// round((cipher_scalar - dot product) / 65536) with negatives clamped to zero.
// Throughput: one item per cycle while not stalled; the key RAM read, the 32x32 multiply,
// the accumulator, the subtract and the rounding each take one register stage.
// A last element passes the input, multiply, accumulator, subtract and rounding
// registers in that order before its result shows on m_axis.
// When the receiver stalls, the finished result holds in the output register and
// items keep flowing; input stalls only when a second result reaches the end of
// the pipeline while the first is still waiting.
// Reset clears the running sum and all pipeline valid flags; the key RAM is not
// cleared and must be loaded before use.
module lwe_decrypt_distance
    import lwe_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [8:0] index, [40:9] key_word, [72:41] vector_word, [104:73] cipher_scalar
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  logic                  s_axis_tlast,
    // [0] action
    input  logic                  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [15:0] distance
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    logic [INDEX_W-1:0] index;
    logic [WORD_W-1:0]  key_word_in;
    logic [WORD_W-1:0]  vector_word_in;
    logic [WORD_W-1:0]  cipher_scalar_in;
    logic               in_range;
    logic               accept;
    logic               advance;
    logic               stall;
    logic [KEY_AW-1:0]  key_addr;
    logic [WORD_W-1:0]  key_rd_data;

    logic               elem_valid_reg;
    logic               elem_last_reg;
    logic               elem_in_range_reg;
    logic [WORD_W-1:0]  elem_vector_reg;
    logic [WORD_W-1:0]  elem_scalar_reg;

    lwe_elem_t          elem;
    lwe_sum_t           sum;
    logic [DIST_W-1:0]  distance;

    assign index            = s_axis_tdata[INDEX_W-1:0];
    assign key_word_in      = s_axis_tdata[INDEX_W+WORD_W-1:INDEX_W];
    assign vector_word_in   = s_axis_tdata[INDEX_W+2*WORD_W-1:INDEX_W+WORD_W];
    assign cipher_scalar_in = s_axis_tdata[INDEX_W+3*WORD_W-1:INDEX_W+2*WORD_W];

    assign in_range      = ({1'b0, index} < (INDEX_W+1)'(KEY_LENGTH));
    assign key_addr      = KEY_AW'(index);
    assign advance       = !stall;
    assign s_axis_tready = advance;
    assign accept        = s_axis_tvalid && advance;

    lwe_ram #(
        .WIDTH (WORD_W),
        .DEPTH (KEY_LENGTH)
    ) u_key_ram (
        .clk     (clk),
        .wr_en   (accept && (s_axis_tuser == ACT_KEY) && in_range),
        .wr_addr (key_addr),
        .wr_data (key_word_in),
        .rd_en   (advance),
        .rd_addr (key_addr),
        .rd_data (key_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elem_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            elem_valid_reg <= accept && (s_axis_tuser == ACT_VECTOR);
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            elem_last_reg     <= s_axis_tlast;
            elem_in_range_reg <= in_range;
            elem_vector_reg   <= vector_word_in;
            elem_scalar_reg   <= cipher_scalar_in;
        end
    end

    assign elem.valid         = elem_valid_reg;
    assign elem.last          = elem_last_reg;
    assign elem.in_range      = elem_in_range_reg;
    assign elem.vector_word   = elem_vector_reg;
    assign elem.cipher_scalar = elem_scalar_reg;

    lwe_mac u_mac (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .elem     (elem),
        .key_word (key_rd_data),
        .sum      (sum)
    );

    lwe_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .sum       (sum),
        .stall     (stall),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .distance  (distance)
    );

    assign m_axis_tdata = OUT_DATA_W'(distance);

endmodule

// File: bench/tb_top.sv
// Self-checking testbench for lwe_decrypt_distance: directed table, random frames, stalls.
module tb_top;
    import lwe_pkg::*;

    localparam int ITEM_TARGET = 1050;
    localparam int IDLE_LIMIT  = 4000;
    localparam int DRAIN_WAIT  = 12;

    typedef struct {
        logic               action;
        logic [INDEX_W-1:0] index;
        logic [WORD_W-1:0]  key_word;
        logic [WORD_W-1:0]  vector_word;
        logic [WORD_W-1:0]  cipher_scalar;
        logic               last;
    } lwe_item_t;

    typedef struct {
        lwe_item_t         item;
        bit                typed;
        logic [DIST_W-1:0] distance;
    } lwe_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  s_axis_tlast;
    logic                  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    logic [WORD_W-1:0] key_table [KEY_LENGTH];
    bit                key_loaded [KEY_LENGTH];
    int                loaded_idx [$];
    logic [WORD_W-1:0] dot_acc;
    logic [DIST_W-1:0] distance_q [$];

    int error_count = 0;
    int item_count;
    int burst_left;
    int idle_cycles = 0;
    int stall_mode  = 0;
    int stall_left  = 0;
    bit stall_phase = 1'b0;

    lwe_decrypt_distance u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    function automatic logic [DIST_W-1:0] round_distance(input logic [WORD_W-1:0] diff);
        logic [WORD_W:0] biased;
        if (diff[WORD_W-1])
            return '0;
        biased = {1'b0, diff} + 33'h8000;
        return biased[FRAC_W+DIST_W-1:FRAC_W];
    endfunction

    function automatic lwe_row_t mk_row(input logic action, input int index,
                                        input logic [31:0] key_word,
                                        input logic [31:0] vector_word,
                                        input logic [31:0] cipher_scalar,
                                        input logic last, input bit typed,
                                        input logic [15:0] distance);
        lwe_row_t r;
        r.item.action        = action;
        r.item.index         = index[INDEX_W-1:0];
        r.item.key_word      = key_word;
        r.item.vector_word   = vector_word;
        r.item.cipher_scalar = cipher_scalar;
        r.item.last          = last;
        r.typed              = typed;
        r.distance           = distance;
        return r;
    endfunction

    function automatic logic [WORD_W-1:0] rand_word();
        case ($urandom_range(0, 9))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'h7FFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] want,
                                   input logic [15:0] got);
        $display("mismatch at %0t: %s want %0d got %0d", $time, what, want, got);
        error_count++;
    endtask

    // Advance the key table and running sum; queue the distance a last element produces.
    task automatic absorb_item(input lwe_item_t it, input bit typed,
                               input logic [DIST_W-1:0] typed_distance);
        logic [WORD_W-1:0] diff;
        if (it.action == ACT_KEY)
        begin
            if (it.index < KEY_LENGTH)
            begin
                key_table[it.index] = it.key_word;
                if (!key_loaded[it.index])
                begin
                    key_loaded[it.index] = 1'b1;
                    loaded_idx.push_back(int'(it.index));
                end
            end
        end
        else
        begin
            if (it.index < KEY_LENGTH)
                dot_acc = dot_acc + it.vector_word * key_table[it.index];
            if (it.last)
            begin
                diff = it.cipher_scalar - dot_acc;
                distance_q.push_back(typed ? typed_distance : round_distance(diff));
                dot_acc = '0;
            end
        end
    endtask

    // Call at a falling edge; returns at the falling edge after the transfer.
    task automatic send_item(input lwe_item_t it, input bit typed,
                             input logic [DIST_W-1:0] typed_distance);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 24);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'b0, it.cipher_scalar, it.vector_word, it.key_word, it.index};
        s_axis_tlast  <= it.last;
        s_axis_tuser  <= it.action;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        absorb_item(it, typed, typed_distance);
        item_count++;
        @(negedge clk);
    endtask

    task automatic send_key_burst();
        lwe_item_t it;
        int n;
        n = $urandom_range(1, 6);
        repeat (n)
        begin
            it.action        = ACT_KEY;
            case ($urandom_range(0, 9))
                0: it.index = '0;
                1: it.index = '1;
                default: it.index = INDEX_W'($urandom_range(0, KEY_LENGTH - 1));
            endcase
            it.key_word      = rand_word();
            it.vector_word   = $urandom;
            it.cipher_scalar = $urandom;
            it.last          = ($urandom_range(0, 9) == 0);
            send_item(it, 1'b0, '0);
        end
    endtask

    task automatic send_frame();
        lwe_item_t it;
        int len;
        logic [WORD_W-1:0] offset;
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6);
        for (int k = 0; k < len; k++)
        begin
            if ($urandom_range(0, 14) == 0)
                send_key_burst();
            it.action        = ACT_VECTOR;
            it.index         = INDEX_W'(loaded_idx[$urandom_range(0, loaded_idx.size() - 1)]);
            it.key_word      = $urandom;
            it.vector_word   = rand_word();
            it.last          = (k == len - 1);
            it.cipher_scalar = $urandom;
            if (it.last && $urandom_range(0, 9) < 6)
            begin
                case ($urandom_range(0, 5))
                    0: offset = 32'h0000_8000;
                    1: offset = 32'h0000_7FFF;
                    2: offset = 32'h0001_8000;
                    3: offset = 32'h7FFF_FFFF;
                    4: offset = 32'h0000_0000;
                    default: offset = $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
                endcase
                it.cipher_scalar = dot_acc + it.vector_word * key_table[it.index] + offset;
            end
            send_item(it, 1'b0, '0);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (distance_q.size() == 0)
                report_mismatch("unexpected distance", '0, m_axis_tdata);
            else
            begin
                if (m_axis_tdata !== distance_q[0])
                    report_mismatch("distance", distance_q[0], m_axis_tdata);
                void'(distance_q.pop_front());
            end
        end
    end

    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 120);
        end
        else
            stall_left--;
        stall_phase = ~stall_phase;
        case (stall_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= 1'($urandom_range(0, 1));
            2: m_axis_tready <= ($urandom_range(0, 7) == 0);
            default: m_axis_tready <= stall_phase;
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("lwe_decrypt_distance regression: fail");
                $finish;
            end
        end
    end

    initial
    begin
        lwe_row_t directed_rows [$];
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        s_axis_tuser  = ACT_KEY;
        dot_acc       = '0;
        item_count    = 0;
        burst_left    = 0;
        for (int i = 0; i < KEY_LENGTH; i++)
            key_loaded[i] = 1'b0;

        directed_rows.push_back(mk_row(ACT_KEY, 0, 32'h0000_0001, 0, 0, 0, 0, 0));
        directed_rows.push_back(mk_row(ACT_KEY, 511, 32'hFFFF_FFFF, 0, 0, 0, 0, 0));
        directed_rows.push_back(mk_row(ACT_KEY, 1, 32'h0001_0000, 0, 0, 0, 0, 0));
        directed_rows.push_back(mk_row(ACT_VECTOR, 0, 0, 0, 32'h0000_0000, 1, 1, 16'd0));
        directed_rows.push_back(mk_row(ACT_VECTOR, 0, 0, 0, 32'h7FFF_FFFF, 1, 1, 16'd32768));
        directed_rows.push_back(mk_row(ACT_VECTOR, 0, 0, 0, 32'h8000_0000, 1, 1, 16'd0));
        directed_rows.push_back(mk_row(ACT_VECTOR, 0, 0, 0, 32'hFFFF_FFFF, 1, 1, 16'd0));
        directed_rows.push_back(mk_row(ACT_VECTOR, 0, 0, 0, 32'h0000_8000, 1, 1, 16'd1));
        directed_rows.push_back(mk_row(ACT_VECTOR, 0, 0, 0, 32'h0000_7FFF, 1, 1, 16'd0));
        directed_rows.push_back(mk_row(ACT_VECTOR, 0, 0, 0, 32'h0001_7FFF, 1, 1, 16'd1));
        directed_rows.push_back(mk_row(ACT_VECTOR, 0, 0, 0, 32'h0001_8000, 1, 1, 16'd2));
        directed_rows.push_back(mk_row(ACT_KEY, 2, 32'h0000_0005, 0, 0, 1, 0, 0));
        directed_rows.push_back(mk_row(ACT_VECTOR, 511, 0, 32'hFFFF_FFFF, 0, 0, 0, 0));
        directed_rows.push_back(mk_row(ACT_VECTOR, 2, 0, 32'h0000_0003, 32'h1234_5678, 0, 0, 0));
        directed_rows.push_back(mk_row(ACT_KEY, 5, 32'hDEAD_BEEF, 0, 0, 1, 0, 0));
        directed_rows.push_back(mk_row(ACT_VECTOR, 1, 0, 32'h0000_FFFF, 32'h0000_0000, 1, 0, 0));
        directed_rows.push_back(mk_row(ACT_KEY, 3, 32'h0000_0007, 0, 0, 0, 0, 0));
        directed_rows.push_back(mk_row(ACT_VECTOR, 3, 0, 32'h0000_0002, 32'h0001_000E, 1, 1, 16'd1));
        directed_rows.push_back(mk_row(ACT_KEY, 0, 32'hFFFF_FFFF, 0, 0, 0, 0, 0));
        directed_rows.push_back(mk_row(ACT_VECTOR, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 0, 0));
        directed_rows.push_back(mk_row(ACT_VECTOR, 511, 0, 32'h8000_0000, 32'h7FFF_0000, 0, 0, 0));
        directed_rows.push_back(mk_row(ACT_VECTOR, 5, 0, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1, 0, 0));

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i])
            send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].distance);

        while (item_count < ITEM_TARGET)
        begin
            if ($urandom_range(0, 99) < 20)
                send_key_burst();
            else
                send_frame();
        end
        s_axis_tvalid <= 1'b0;

        while (distance_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (error_count == 0)
            $display("lwe_decrypt_distance regression: pass");
        else
            $display("lwe_decrypt_distance regression: fail");
        $finish;
    end

endmodule

// File: filelist.f
hdl/lwe_pkg.sv
hdl/lwe_ram.sv
hdl/lwe_mac.sv
hdl/lwe_scale.sv
hdl/lwe_decrypt_distance.sv
bench/tb_top.sv
